FILE: rtl/shortest_path_bellman_ford_assert.svh
// Assertion macros used by the shortest path engine RTL.
// Needs no other file; the bodies are empty when SYNTH is defined.
`ifndef SHORTEST_PATH_BELLMAN_FORD_ASSERT_SVH
`define SHORTEST_PATH_BELLMAN_FORD_ASSERT_SVH
`ifndef SYNTH
`define SPBF_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("shortest path block: same-cycle check failed");
`define SPBF_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("shortest path block: next-cycle check failed");
`else
`define SPBF_ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define SPBF_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/spbf_pkg.sv
// Package for the shortest path block: constants, beat types, configuration codes.
// Used by every module of the block but spbf_fifo; depends on nothing.
package spbf_pkg;

    localparam int MAX_NODES     = 16;
    localparam int NODE_W        = $clog2(MAX_NODES);
    localparam int COUNT_W       = $clog2(MAX_NODES + 1);
    localparam int WEIGHT_W      = 8;
    localparam int DIST_W        = 16;
    localparam int MAX_EDGES_DEF = 64;
    localparam int QUEUE_DEPTH   = 2;
    localparam int CFG_DATA_W    = COUNT_W;

    localparam logic [NODE_W-1:0]  SOURCE_RESET     = '0;
    localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = COUNT_W'(10);

    typedef enum logic [0:0] {
        CFG_SOURCE_NODE = 1'b0,
        CFG_NODE_COUNT  = 1'b1
    } t_cfg_reg;

    typedef enum logic [0:0] {
        CMD_STORE = 1'b0,
        CMD_RUN   = 1'b1
    } t_cmd_kind;

    typedef struct packed {
        logic [NODE_W-1:0]          edge_from;
        logic [NODE_W-1:0]          edge_to;
        logic signed [WEIGHT_W-1:0] edge_weight;
        logic                       last_edge;
    } t_edge_beat;

    typedef struct packed {
        logic [NODE_W-1:0]        node_index;
        logic signed [DIST_W-1:0] distance;
        logic                     reachable;
        logic [NODE_W-1:0]        parent_node;
        logic                     last_node;
    } t_result;

    typedef struct packed {
        logic [NODE_W-1:0]          edge_from;
        logic [NODE_W-1:0]          edge_to;
        logic signed [WEIGHT_W-1:0] edge_weight;
    } t_edge_rec;

    typedef struct packed {
        t_cmd_kind kind;
        t_edge_rec rec;
    } t_edge_cmd;

    typedef struct packed {
        logic [NODE_W-1:0]  source_node;
        logic [COUNT_W-1:0] node_count;
    } t_cfg;

    function automatic logic [COUNT_W-1:0] nodes_in_use(input logic [COUNT_W-1:0] cnt);
        logic [COUNT_W-1:0] res;
        priority if (cnt == '0) begin
            res = COUNT_W'(1);
        end else if (cnt > COUNT_W'(MAX_NODES)) begin
            res = COUNT_W'(MAX_NODES);
        end else begin
            res = cnt;
        end
        return res;
    endfunction

endpackage

FILE: rtl/spbf_fifo.sv
// Small first-in first-out queue of any packed item type.
// Depends on nothing; used between the front and the engine and at the result side.
module spbf_fifo #(
    parameter int  DEPTH  = 2,
    parameter type t_item = logic
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              push_ok;
    logic              pop_ok;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

FILE: rtl/spbf_front.sv
// Input side: takes edge beats, tags each as a plain store or a run trigger, and queues it.
// Depends on spbf_pkg and spbf_fifo.
module spbf_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  spbf_pkg::t_edge_beat  i_edge,
    output logic                  o_full,
    input  logic                  i_cmd_pop,
    output logic                  o_cmd_valid,
    output spbf_pkg::t_edge_cmd   o_cmd
);

    spbf_pkg::t_edge_cmd cmd_in;
    logic                cmd_empty;

    always_comb begin
        cmd_in.kind            = i_edge.last_edge ? spbf_pkg::CMD_RUN : spbf_pkg::CMD_STORE;
        cmd_in.rec.edge_from   = i_edge.edge_from;
        cmd_in.rec.edge_to     = i_edge.edge_to;
        cmd_in.rec.edge_weight = i_edge.edge_weight;
    end

    spbf_fifo #(
        .DEPTH  (spbf_pkg::QUEUE_DEPTH),
        .t_item (spbf_pkg::t_edge_cmd)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_item  (cmd_in),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_item  (o_cmd),
        .o_empty (cmd_empty)
    );

    assign o_cmd_valid = !cmd_empty;

endmodule

FILE: rtl/spbf_engine.sv
// Back end: edge store, relaxation sequencer over node memories, and result emission.
// Depends on spbf_pkg and the assertion macros in shortest_path_bellman_ford_assert.svh.
`include "shortest_path_bellman_ford_assert.svh"
module spbf_engine #(
    parameter int MAX_EDGES = spbf_pkg::MAX_EDGES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spbf_pkg::t_cfg      i_cfg,
    input  logic                i_cmd_valid,
    input  spbf_pkg::t_edge_cmd i_cmd,
    output logic                o_cmd_pop,
    input  logic                i_out_full,
    output logic                o_out_push,
    output spbf_pkg::t_result   o_result
);

    localparam int NODE_W  = spbf_pkg::NODE_W;
    localparam int COUNT_W = spbf_pkg::COUNT_W;
    localparam int DIST_W  = spbf_pkg::DIST_W;
    localparam int NODES   = spbf_pkg::MAX_NODES;
    localparam int EIDX_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ETOT_W  = $clog2(MAX_EDGES + 1);

    typedef enum logic [2:0] {
        S_LOAD,
        S_FETCH,
        S_NODE,
        S_RELAX,
        S_EMIT_RD,
        S_EMIT_WR
    } t_state;

    t_state                   r_state;
    logic [ETOT_W-1:0]        r_total;
    logic [ETOT_W-1:0]        r_edge_idx;
    logic [NODE_W-1:0]        r_round;
    logic [COUNT_W-1:0]       r_n;
    logic [COUNT_W-1:0]       r_out_idx;
    logic [NODES-1:0]         r_reached;

    spbf_pkg::t_edge_rec      r_edge_mem [MAX_EDGES];
    logic signed [DIST_W-1:0] r_dist_mem [NODES];
    logic [NODE_W-1:0]        r_parent_mem [NODES];
    spbf_pkg::t_edge_rec      r_edge_q;
    logic signed [DIST_W-1:0] r_dist_a;
    logic signed [DIST_W-1:0] r_dist_b;
    logic [NODE_W-1:0]        r_parent_q;

    logic                     load_pop;
    logic                     store_ok;
    logic                     run_start;
    logic [COUNT_W-1:0]       nodes_used;
    logic                     src_in;
    logic                     round_done;
    logic                     edge_end;
    logic [NODE_W-1:0]        u_node;
    logic [NODE_W-1:0]        v_node;
    logic                     edge_in_use;
    logic [DIST_W:0]          sum_wide;
    logic signed [DIST_W-1:0] cand;
    logic                     do_relax;
    logic                     emitting;
    logic [NODE_W-1:0]        rd_a_addr;
    logic [NODE_W-1:0]        out_node;
    logic                     out_last;
    logic                     node_wr;
    logic [NODE_W-1:0]        node_wr_addr;
    logic signed [DIST_W-1:0] node_wr_dist;
    logic [NODE_W-1:0]        node_wr_parent;

    assign load_pop   = (r_state == S_LOAD) && i_cmd_valid;
    assign o_cmd_pop  = load_pop;
    assign store_ok   = (r_total < ETOT_W'(MAX_EDGES));
    assign run_start  = load_pop && (i_cmd.kind == spbf_pkg::CMD_RUN);
    assign nodes_used = spbf_pkg::nodes_in_use(i_cfg.node_count);
    assign src_in     = (COUNT_W'(i_cfg.source_node) < nodes_used);
    assign round_done = ((COUNT_W'(r_round) + COUNT_W'(1)) >= r_n);
    assign edge_end   = (r_edge_idx == r_total);

    assign u_node      = r_edge_q.edge_from;
    assign v_node      = r_edge_q.edge_to;
    assign edge_in_use = (COUNT_W'(u_node) < r_n) && (COUNT_W'(v_node) < r_n);
    assign sum_wide    = {r_dist_a[DIST_W-1], r_dist_a}
                       + {{(DIST_W + 1 - spbf_pkg::WEIGHT_W){r_edge_q.edge_weight[spbf_pkg::WEIGHT_W-1]}},
                          r_edge_q.edge_weight};

    always_comb begin
        if (sum_wide[DIST_W] != sum_wide[DIST_W-1]) begin
            cand = sum_wide[DIST_W] ? {1'b1, {(DIST_W - 1){1'b0}}} : {1'b0, {(DIST_W - 1){1'b1}}};
        end else begin
            cand = sum_wide[DIST_W-1:0];
        end
    end

    assign do_relax = (r_state == S_RELAX) && edge_in_use && r_reached[u_node]
                    && (!r_reached[v_node] || (cand < r_dist_b));

    assign emitting  = (r_state == S_EMIT_RD) || (r_state == S_EMIT_WR);
    assign rd_a_addr = emitting ? r_out_idx[NODE_W-1:0] : u_node;

    assign node_wr        = run_start || do_relax;
    assign node_wr_addr   = run_start ? i_cfg.source_node : v_node;
    assign node_wr_dist   = run_start ? '0 : cand;
    assign node_wr_parent = run_start ? i_cfg.source_node : u_node;

    always_ff @(posedge i_clk) begin
        if (load_pop && store_ok) begin
            r_edge_mem[r_total[EIDX_W-1:0]] <= i_cmd.rec;
        end
        r_edge_q <= r_edge_mem[r_edge_idx[EIDX_W-1:0]];
        if (node_wr) begin
            r_dist_mem[node_wr_addr]   <= node_wr_dist;
            r_parent_mem[node_wr_addr] <= node_wr_parent;
        end
        r_dist_a   <= r_dist_mem[rd_a_addr];
        r_dist_b   <= r_dist_mem[v_node];
        r_parent_q <= r_parent_mem[rd_a_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_total    <= '0;
            r_edge_idx <= '0;
            r_round    <= '0;
            r_n        <= COUNT_W'(1);
            r_out_idx  <= '0;
            r_reached  <= '0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (load_pop) begin
                        if (store_ok) begin
                            r_total <= r_total + ETOT_W'(1);
                        end
                        if (run_start) begin
                            r_n        <= nodes_used;
                            r_reached  <= src_in ? ({{(NODES - 1){1'b0}}, 1'b1} << i_cfg.source_node)
                                                 : '0;
                            r_round    <= '0;
                            r_edge_idx <= '0;
                            r_state    <= S_FETCH;
                        end
                    end
                end
                S_FETCH: begin
                    if (round_done) begin
                        r_out_idx <= '0;
                        r_state   <= S_EMIT_RD;
                    end else if (edge_end) begin
                        r_round    <= r_round + NODE_W'(1);
                        r_edge_idx <= '0;
                    end else begin
                        r_state <= S_NODE;
                    end
                end
                S_NODE: begin
                    r_state <= S_RELAX;
                end
                S_RELAX: begin
                    if (do_relax) begin
                        r_reached[v_node] <= 1'b1;
                    end
                    r_edge_idx <= r_edge_idx + ETOT_W'(1);
                    r_state    <= S_FETCH;
                end
                S_EMIT_RD: begin
                    r_state <= S_EMIT_WR;
                end
                S_EMIT_WR: begin
                    if (!i_out_full) begin
                        if (out_last) begin
                            r_total <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_out_idx <= r_out_idx + COUNT_W'(1);
                            r_state   <= S_EMIT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign out_node   = r_out_idx[NODE_W-1:0];
    assign out_last   = ((r_out_idx + COUNT_W'(1)) == r_n);
    assign o_out_push = (r_state == S_EMIT_WR);

    always_comb begin
        o_result.node_index  = out_node;
        o_result.reachable   = r_reached[out_node];
        o_result.distance    = r_reached[out_node] ? r_dist_a : '0;
        o_result.parent_node = r_reached[out_node] ? r_parent_q : out_node;
        o_result.last_node   = out_last;
    end

    `SPBF_ASSERT_IMPLY(a_total_bound, i_clk, i_rst_n, 1'b1, r_total <= ETOT_W'(MAX_EDGES))
    `SPBF_ASSERT_IMPLY(a_relax_in_range, i_clk, i_rst_n, r_state == S_RELAX, r_edge_idx < r_total)
    `SPBF_ASSERT_IMPLY(a_emit_in_range, i_clk, i_rst_n, r_state == S_EMIT_WR, r_out_idx < r_n)
    `SPBF_ASSERT_NEXT(a_run_leaves_load, i_clk, i_rst_n, run_start, r_state == S_FETCH)
    `SPBF_ASSERT_NEXT(a_source_reached, i_clk, i_rst_n, run_start && src_in, r_reached[$past(i_cfg.source_node)])

endmodule

FILE: rtl/shortest_path_bellman_ford.sv
// Top level of the single-source shortest path block: configuration registers and wiring.
// Depends on spbf_pkg, spbf_front, spbf_engine and spbf_fifo.
//
// Edges are pushed one per beat into a two-entry queue and written to the edge store at one
// per cycle while the engine is loading. The beat marked last starts a run of (n - 1)
// rounds over the stored edges; one edge step is a registered edge-store read, a
// registered read of both node distances, then the compare and write-back. Results then
// follow, one registered node-memory read per result, into a two-entry result queue. No new
// edge is stored until the last result of a run has entered that queue; edges pushed
// meanwhile wait in the input queue.
module shortest_path_bellman_ford #(
    parameter int MAX_EDGES = spbf_pkg::MAX_EDGES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  spbf_pkg::t_edge_beat                i_edge,
    output logic                                empty,
    input  logic                                pop,
    output spbf_pkg::t_result                   o_result,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [0:0]                          i_cfg_index,
    input  logic [spbf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [spbf_pkg::NODE_W-1:0]  r_source;
    logic [spbf_pkg::COUNT_W-1:0] r_node_count;
    spbf_pkg::t_cfg               cfg;
    logic                         cmd_valid;
    logic                         cmd_pop;
    spbf_pkg::t_edge_cmd          cmd;
    logic                         out_full;
    logic                         out_push;
    spbf_pkg::t_result            out_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source     <= spbf_pkg::SOURCE_RESET;
            r_node_count <= spbf_pkg::NODE_COUNT_RESET;
        end else if (i_cfg_valid) begin
            unique case (spbf_pkg::t_cfg_reg'(i_cfg_index))
                spbf_pkg::CFG_SOURCE_NODE: begin
                    r_source <= i_cfg_data[spbf_pkg::NODE_W-1:0];
                end
                spbf_pkg::CFG_NODE_COUNT: begin
                    r_node_count <= i_cfg_data;
                end
            endcase
        end
    end

    always_comb begin
        cfg.source_node = r_source;
        cfg.node_count  = r_node_count;
    end

    spbf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_edge      (i_edge),
        .o_full      (full),
        .i_cmd_pop   (cmd_pop),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    spbf_engine #(
        .MAX_EDGES (MAX_EDGES)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_out_full  (out_full),
        .o_out_push  (out_push),
        .o_result    (out_result)
    );

    spbf_fifo #(
        .DEPTH  (spbf_pkg::QUEUE_DEPTH),
        .t_item (spbf_pkg::t_result)
    ) u_result_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_item  (out_result),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_item  (o_result),
        .o_empty (empty)
    );

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the single-source shortest path block.
// Needs spbf_pkg and the shortest_path_bellman_ford RTL; predicts every node report itself.
`timescale 1ns / 100ps

module tb;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 600;
    localparam int QUIET_LIMIT   = 20000;
    localparam int RANDOM_ITEMS  = 104;
    localparam int DIR_ROWS      = 24;
    localparam int BEAT_W        = $bits(spbf_pkg::t_edge_beat);

    typedef enum logic {
        ROW_CFG,
        ROW_EDGE
    } t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        spbf_pkg::t_cfg_reg   reg_sel;
        logic [4:0]           reg_val;
        spbf_pkg::t_edge_beat beat;
        logic [1:0]           n_typed;
        spbf_pkg::t_result    typed0;
        spbf_pkg::t_result    typed1;
    } t_dir_row;

    localparam spbf_pkg::t_result NODE0_ALONE    = '{4'd0, 16'sd0, 1'b1, 4'd0, 1'b1};
    localparam spbf_pkg::t_result NODE0_CUT      = '{4'd0, 16'sd0, 1'b0, 4'd0, 1'b0};
    localparam spbf_pkg::t_result NODE1_CUT_LAST = '{4'd1, 16'sd0, 1'b0, 4'd1, 1'b1};

    localparam spbf_pkg::t_cfg_reg SRC = spbf_pkg::CFG_SOURCE_NODE;
    localparam spbf_pkg::t_cfg_reg CNT = spbf_pkg::CFG_NODE_COUNT;

    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        '{ROW_EDGE, SRC, 5'd0,  '{4'd0,  4'd1,  8'h05, 1'b1}, 2'd0, '0, '0},
        '{ROW_CFG,  CNT, 5'd1,  '0, 2'd0, '0, '0},
        '{ROW_EDGE, SRC, 5'd0,  '{4'd15, 4'd15, 8'h80, 1'b1}, 2'd1, NODE0_ALONE, '0},
        '{ROW_CFG,  CNT, 5'd0,  '0, 2'd0, '0, '0},
        '{ROW_EDGE, SRC, 5'd0,  '{4'd0,  4'd0,  8'h7f, 1'b1}, 2'd1, NODE0_ALONE, '0},
        '{ROW_CFG,  SRC, 5'd15, '0, 2'd0, '0, '0},
        '{ROW_CFG,  CNT, 5'd2,  '0, 2'd0, '0, '0},
        '{ROW_EDGE, SRC, 5'd0,  '{4'd0,  4'd1,  8'h01, 1'b1}, 2'd2,
          NODE0_CUT, NODE1_CUT_LAST},
        '{ROW_CFG,  SRC, 5'd0,  '0, 2'd0, '0, '0},
        '{ROW_CFG,  CNT, 5'd31, '0, 2'd0, '0, '0},
        '{ROW_EDGE, SRC, 5'd0,  '{4'd14, 4'd15, 8'h03, 1'b0}, 2'd0, '0, '0},
        '{ROW_EDGE, SRC, 5'd0,  '{4'd0,  4'd14, 8'h7f, 1'b0}, 2'd0, '0, '0},
        '{ROW_EDGE, SRC, 5'd0,  '{4'd0,  4'd15, 8'h7f, 1'b0}, 2'd0, '0, '0},
        '{ROW_EDGE, SRC, 5'd0,  '{4'd15, 4'd1,  8'h80, 1'b0}, 2'd0, '0, '0},
        '{ROW_EDGE, SRC, 5'd0,  '{4'd3,  4'd2,  8'hff, 1'b0}, 2'd0, '0, '0},
        '{ROW_EDGE, SRC, 5'd0,  '{4'd1,  4'd2,  8'h80, 1'b0}, 2'd0, '0, '0},
        '{ROW_EDGE, SRC, 5'd0,  '{4'd2,  4'd13, 8'h00, 1'b0}, 2'd0, '0, '0},
        '{ROW_EDGE, SRC, 5'd0,  '{4'd13, 4'd2,  8'h80, 1'b0}, 2'd0, '0, '0},
        '{ROW_EDGE, SRC, 5'd0,  '{4'd13, 4'd12, 8'h55, 1'b1}, 2'd0, '0, '0},
        '{ROW_CFG,  SRC, 5'd15, '0, 2'd0, '0, '0},
        '{ROW_CFG,  CNT, 5'd16, '0, 2'd0, '0, '0},
        '{ROW_EDGE, SRC, 5'd0,  '{4'd15, 4'd10, 8'haa, 1'b0}, 2'd0, '0, '0},
        '{ROW_EDGE, SRC, 5'd0,  '{4'd10, 4'd15, 8'h01, 1'b0}, 2'd0, '0, '0},
        '{ROW_EDGE, SRC, 5'd0,  '{4'd10, 4'd5,  8'hff, 1'b1}, 2'd0, '0, '0}
    };

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            push;
    logic                            full;
    spbf_pkg::t_edge_beat            i_edge;
    logic                            empty;
    logic                            pop;
    spbf_pkg::t_result               o_result;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [0:0]                      i_cfg_index;
    logic [spbf_pkg::CFG_DATA_W-1:0] i_cfg_data;

    spbf_pkg::t_edge_rec graph_edges [spbf_pkg::MAX_EDGES_DEF];
    int unsigned         graph_size;
    logic [3:0]          cfg_source;
    logic [4:0]          cfg_count;
    spbf_pkg::t_result   reports_due [$];
    int                  mismatches = 0;
    int                  items_sent;
    int                  quiet_cycles = 0;
    bit                  gaps_on;
    int                  hold_requests = 0;

    shortest_path_bellman_ford u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_edge      (i_edge),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int unsigned active_nodes(input logic [4:0] cnt);
        if (cnt == 5'd0) begin
            return 1;
        end
        return (cnt > 5'd16) ? 16 : int'(cnt);
    endfunction

    function automatic void solve_paths(output spbf_pkg::t_result found [$]);
        int                node_dist [16];
        bit                reached [16];
        logic [3:0]        parent [16];
        int unsigned       n;
        int                u;
        int                v;
        int                cand;
        spbf_pkg::t_result rep;
        n = active_nodes(cfg_count);
        found = {};
        for (int i = 0; i < 16; i++) begin
            node_dist[i] = 0;
            reached[i] = 1'b0;
            parent[i] = 4'(i);
        end
        if (cfg_source < n) begin
            reached[cfg_source] = 1'b1;
        end
        for (int r = 0; r + 1 < n; r++) begin
            for (int e = 0; e < graph_size; e++) begin
                u = graph_edges[e].edge_from;
                v = graph_edges[e].edge_to;
                if (u >= n || v >= n || !reached[u]) begin
                    continue;
                end
                cand = node_dist[u] + int'(graph_edges[e].edge_weight);
                if (cand > 32767) begin
                    cand = 32767;
                end else if (cand < -32768) begin
                    cand = -32768;
                end
                if (!reached[v] || cand < node_dist[v]) begin
                    node_dist[v] = cand;
                    reached[v] = 1'b1;
                    parent[v] = 4'(u);
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            rep.node_index  = 4'(i);
            rep.reachable   = reached[i];
            rep.distance    = reached[i] ? 16'(node_dist[i]) : 16'sd0;
            rep.parent_node = reached[i] ? parent[i] : 4'(i);
            rep.last_node   = (i + 1 == n);
            found = {found, rep};
        end
        graph_size = 0;
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (reports_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input spbf_pkg::t_cfg_reg sel, input logic [4:0] val);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (sel == spbf_pkg::CFG_SOURCE_NODE) begin
            cfg_source = val[3:0];
        end else begin
            cfg_count = val;
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_edge(input spbf_pkg::t_edge_beat beat, input logic [1:0] n_typed,
                             input spbf_pkg::t_result t0, input spbf_pkg::t_result t1);
        spbf_pkg::t_result found [$];
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            push   <= 1'b0;
            i_edge <= BEAT_W'($urandom);
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        push   <= 1'b1;
        i_edge <= beat;
        do @(posedge i_clk); while (full);
        items_sent++;
        if (graph_size < spbf_pkg::MAX_EDGES_DEF) begin
            graph_edges[graph_size] = '{beat.edge_from, beat.edge_to, beat.edge_weight};
            graph_size++;
        end
        if (beat.last_edge) begin
            solve_paths(found);
            if (n_typed == 2'd0) begin
                foreach (found[i]) reports_due = {reports_due, found[i]};
            end else begin
                reports_due = {reports_due, t0};
                if (n_typed > 2'd1) begin
                    reports_due = {reports_due, t1};
                end
            end
        end
        @(negedge i_clk);
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        int holds_served;
        holds_served = 0;
        pop = 1'b0;
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            @(negedge i_clk);
            if (hold_requests != holds_served) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                holds_served++;
            end else if (gaps_on && $urandom_range(0, 7) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(0, 16)) @(negedge i_clk);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        spbf_pkg::t_result due;
        if (i_rst_n && pop && !empty) begin
            if (reports_due.size() == 0) begin
                flag_mismatch("node report with nothing due, node", o_result.node_index, -1);
            end else begin
                due = reports_due.pop_front();
                if (o_result.node_index !== due.node_index)
                    flag_mismatch("node_index", o_result.node_index, due.node_index);
                if (o_result.distance !== due.distance)
                    flag_mismatch("distance", o_result.distance, due.distance);
                if (o_result.reachable !== due.reachable)
                    flag_mismatch("reachable", o_result.reachable, due.reachable);
                if (o_result.parent_node !== due.parent_node)
                    flag_mismatch("parent_node", o_result.parent_node, due.parent_node);
                if (o_result.last_node !== due.last_node)
                    flag_mismatch("last_node", o_result.last_node, due.last_node);
            end
        end
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("** shortest_path_bellman_ford: FAILED **");
        $finish;
    end

    initial begin
        spbf_pkg::t_edge_beat beat;
        int unsigned          n;
        int                   rand_end;
        int                   graph_no;
        int                   n_edges;
        logic [4:0]           new_count;

        push         = 1'b0;
        i_edge       = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_rst_n      = 1'b0;
        graph_size   = 0;
        cfg_source   = 4'd0;
        cfg_count    = 5'd10;
        items_sent   = 0;
        gaps_on      = 1'b1;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].kind == ROW_CFG) begin
                write_reg(DIRECTED[i].reg_sel, DIRECTED[i].reg_val);
            end else begin
                send_edge(DIRECTED[i].beat, DIRECTED[i].n_typed,
                          DIRECTED[i].typed0, DIRECTED[i].typed1);
            end
        end

        rand_end = items_sent + RANDOM_ITEMS;
        graph_no = 0;
        while (items_sent < rand_end) begin
            gaps_on = (items_sent < rand_end - RANDOM_ITEMS / 4);
            if (graph_no == 2) begin
                // Overflows the edge store with a tight negative cycle, so sums saturate.
                write_reg(spbf_pkg::CFG_NODE_COUNT, 5'd16);
                write_reg(spbf_pkg::CFG_SOURCE_NODE, 5'd0);
                for (int k = 0; k < spbf_pkg::MAX_EDGES_DEF + 2; k++) begin
                    beat.edge_from   = k[0] ? 4'd1 : 4'd0;
                    beat.edge_to     = k[0] ? 4'd0 : 4'd1;
                    beat.edge_weight = 8'($urandom_range(128, 156));
                    beat.last_edge   = (k == spbf_pkg::MAX_EDGES_DEF + 1);
                    send_edge(beat, 2'd0, '0, '0);
                end
            end else begin
                if (graph_no != 5 && $urandom_range(0, 2) == 0) begin
                    new_count = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                                            : 5'($urandom_range(2, 8));
                    write_reg(spbf_pkg::CFG_NODE_COUNT, new_count);
                    n = active_nodes(new_count);
                    write_reg(spbf_pkg::CFG_SOURCE_NODE,
                              ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                          : 5'($urandom_range(0, n - 1)));
                end
                n = active_nodes(cfg_count);
                n_edges = $urandom_range((graph_no == 5) ? 4 : 1, 8);
                for (int k = 0; k < n_edges; k++) begin
                    beat.edge_from = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                                                 : 4'($urandom_range(0, n - 1));
                    if (k == 0 && $urandom_range(0, 3) != 0) begin
                        beat.edge_from = cfg_source;
                    end
                    beat.edge_to = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                                               : 4'($urandom_range(0, n - 1));
                    beat.edge_weight = ($urandom_range(0, 3) == 0)
                                       ? 8'($urandom_range(0, 50) - 10)
                                       : 8'($urandom_range(0, 255));
                    beat.last_edge = (k == n_edges - 1);
                    send_edge(beat, 2'd0, '0, '0);
                end
                if (graph_no == 4) begin
                    hold_requests++;
                end
            end
            graph_no++;
        end

        gaps_on = 1'b0;
        wait_idle();
        if (mismatches == 0) begin
            $display("** shortest_path_bellman_ford: PASSED **");
        end else begin
            $display("** shortest_path_bellman_ford: FAILED **");
        end
        $finish;
    end

endmodule
